/* hw/rtl/sptk_pkg.sv */
package sptk_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int VALUE_BITS = 32;
	localparam int MANT_BITS  = 64;

	// signed decimal exponent carried with a number, covers -286 .. 510
	localparam int EXP_W = 11;

	// scaling work register and its division limbs
	localparam int WORK_W = 128;
	localparam int LIMB_W = 16;
	localparam int NLIMB  = WORK_W / LIMB_W;
	localparam int LIMB_IDX_W = $clog2(NLIMB);

	// floor(t / 10) = (t * RECIP10) >> RECIP_SHIFT for every t below 10 * 2^16
	localparam logic [19:0] RECIP10 = 20'd838861;
	localparam int RECIP_SHIFT = 23;

	localparam logic [63:0] POS_MAX = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [3:0] CMD_MOVE   = 4'd0;
	localparam logic [3:0] CMD_CLOSE  = 4'd1;
	localparam logic [3:0] CMD_LINE   = 4'd2;
	localparam logic [3:0] CMD_HLINE  = 4'd3;
	localparam logic [3:0] CMD_VLINE  = 4'd4;
	localparam logic [3:0] CMD_CUBIC  = 4'd5;
	localparam logic [3:0] CMD_SCUBIC = 4'd6;
	localparam logic [3:0] CMD_QUAD   = 4'd7;
	localparam logic [3:0] CMD_SQUAD  = 4'd8;
	localparam logic [3:0] CMD_ARC    = 4'd9;
	localparam logic [3:0] CMD_NONE   = 4'd15;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNKNOWN   = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_NOT_MOVE  = 3'd3;
	localparam logic [2:0] ST_SATURATED = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SIGN,
		PH_INT,
		PH_DOT,
		PH_FRAC,
		PH_EXP,
		PH_EXPSIGN,
		PH_EXPDIG
	} phase_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_FIN,
		B_OUT
	} bstate_t;

	// one result request from the front to the back
	typedef struct packed {
		logic                        conv;
		logic                        one;
		logic                        neg;
		logic [MANT_BITS-1:0]        mant;
		logic signed [EXP_W-1:0]     expo;
		logic [3:0]                  cmd;
		logic                        abs_mode;
		logic [2:0]                  idx;
		logic                        done;
		logic [2:0]                  status;
		logic                        last;
	} qent_t;

	typedef struct packed {
		logic [1:0] n;
		qent_t      a;
		qent_t      b;
	} qpush_t;

	typedef struct packed {
		logic [3:0]  cmd;
		logic        abs_mode;
		logic [2:0]  idx;
		logic [31:0] value;
		logic        done;
		logic [2:0]  status;
		logic        last;
	} res_t;

	function automatic logic [2:0] arg_count(logic [3:0] cmd);
		logic [2:0] r;
		unique case (cmd)
			CMD_MOVE:   r = 3'd2;
			CMD_CLOSE:  r = 3'd0;
			CMD_LINE:   r = 3'd2;
			CMD_HLINE:  r = 3'd1;
			CMD_VLINE:  r = 3'd1;
			CMD_CUBIC:  r = 3'd6;
			CMD_SCUBIC: r = 3'd4;
			CMD_QUAD:   r = 3'd4;
			CMD_SQUAD:  r = 3'd2;
			CMD_ARC:    r = 3'd7;
			default:    r = 3'd1;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/sptk_front.sv */
module sptk_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      text_char,
	input  logic            end_of_text,
	input  logic            take,
	output sptk_pkg::qpush_t push
);
	import sptk_pkg::*;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UE    = 8'h45;

	typedef struct packed {
		logic [3:0]           cmd;
		logic                 abs_mode;
		logic [2:0]           pos;
		phase_t               phase;
		logic                 neg;
		logic [MANT_BITS-1:0] mant;
		logic [4:0]           fdig;
		logic [7:0]           expo;
		logic                 eneg;
		logic                 first;
		logic                 await_grp;
		logic                 comma;
		logic [7:0]           drop;
	} fst_t;

	fst_t st_q, st_d;
	qpush_t push_d;

	function automatic fst_t clear_num(fst_t s);
		s.phase = PH_IDLE;
		s.neg   = 1'b0;
		s.mant  = '0;
		s.fdig  = '0;
		s.expo  = '0;
		s.eneg  = 1'b0;
		s.drop  = '0;
		return s;
	endfunction

	function automatic fst_t reset_st();
		fst_t s;
		s = '0;
		s = clear_num(s);
		s.cmd = CMD_NONE;
		return s;
	endfunction

	function automatic logic [2:0] nargs(logic [3:0] cmd);
		return arg_count(cmd);
	endfunction

	function automatic fst_t add_digit(fst_t s, logic [3:0] d, logic frac);
		logic [MANT_BITS+3:0] t;
		t = (MANT_BITS+4)'({s.mant, 3'b000}) + (MANT_BITS+4)'({s.mant, 1'b0})
			+ (MANT_BITS+4)'(d);
		if (!(frac && s.fdig == 5'd31)) begin
			if (t[MANT_BITS+3:MANT_BITS] == 4'd0) begin
				s.mant = t[MANT_BITS-1:0];
				if (frac)
					s.fdig = s.fdig + 5'd1;
			end else if (!frac && s.drop != 8'd255) begin
				s.drop = s.drop + 8'd1;
			end
		end
		return s;
	endfunction

	function automatic fst_t add_exp(fst_t s, logic [3:0] d);
		logic [11:0] v;
		v = {1'b0, s.expo, 3'b000} + {3'b000, s.expo, 1'b0} + {8'd0, d};
		s.expo = (v > 12'd255) ? 8'd255 : v[7:0];
		return s;
	endfunction

	function automatic qpush_t put(qpush_t p, qent_t x);
		if (p.n == 2'd0)
			p.a = x;
		else if (p.n == 2'd1)
			p.b = x;
		if (p.n != 2'd2)
			p.n = p.n + 2'd1;
		return p;
	endfunction

	function automatic qent_t arg_ent(fst_t s, logic conv, logic one);
		qent_t x;
		logic signed [EXP_W-1:0] e;
		e = $signed({3'b000, s.drop}) - $signed({6'd0, s.fdig});
		if (s.eneg)
			e = e - $signed({3'b000, s.expo});
		else
			e = e + $signed({3'b000, s.expo});
		x = '0;
		x.conv     = conv;
		x.one      = one;
		x.neg      = s.neg;
		x.mant     = s.mant;
		x.expo     = e;
		x.cmd      = s.cmd;
		x.abs_mode = s.abs_mode;
		x.idx      = s.pos;
		x.done     = ({1'b0, s.pos} + 4'd1) >= {1'b0, nargs(s.cmd)};
		x.status   = ST_OK;
		return x;
	endfunction

	function automatic fst_t complete_st(fst_t s);
		if (({1'b0, s.pos} + 4'd1) >= {1'b0, nargs(s.cmd)}) begin
			s.pos = 3'd0;
			s.await_grp = 1'b0;
			if (s.cmd == CMD_MOVE)
				s.cmd = CMD_LINE;
		end else begin
			s.pos = s.pos + 3'd1;
		end
		s.comma = 1'b1;
		return s;
	endfunction

	function automatic void raise(inout fst_t s, inout qpush_t p, input logic [2:0] code);
		qent_t x;
		x = '0;
		x.status = code;
		p = put(p, x);
		s = clear_num(s);
		s.pos = 3'd0;
		s.await_grp = 1'b0;
		s.comma = 1'b0;
	endfunction

	function automatic void finish(inout fst_t s, inout qpush_t p, output logic err);
		if (s.phase == PH_SIGN || s.phase == PH_DOT || s.phase == PH_EXP
			|| s.phase == PH_EXPSIGN) begin
			raise(s, p, ST_MALFORMED);
			err = 1'b1;
		end else begin
			p = put(p, arg_ent(s, 1'b1, 1'b0));
			s = clear_num(s);
			s = complete_st(s);
			err = 1'b0;
		end
	endfunction

	// {hit, upper case, command code}
	function automatic logic [5:0] letter(logic [7:0] c);
		logic [3:0] code;
		logic hit;
		hit = 1'b1;
		unique case (c & 8'hdf)
			8'h4d:   code = CMD_MOVE;
			8'h5a:   code = CMD_CLOSE;
			8'h4c:   code = CMD_LINE;
			8'h48:   code = CMD_HLINE;
			8'h56:   code = CMD_VLINE;
			8'h43:   code = CMD_CUBIC;
			8'h53:   code = CMD_SCUBIC;
			8'h51:   code = CMD_QUAD;
			8'h54:   code = CMD_SQUAD;
			8'h41:   code = CMD_ARC;
			default: begin
				code = CMD_NONE;
				hit = 1'b0;
			end
		endcase
		return {hit, !c[5], code};
	endfunction

	always_comb begin
		fst_t s;
		qpush_t p;
		qent_t x;
		logic err, taken, ext, dig, is_e, ws, sgn;
		logic [3:0] d;
		logic [5:0] lt;
		s = st_q;
		p = '0;
		x = '0;
		err = 1'b0;
		taken = 1'b0;
		ext = 1'b0;
		dig = text_char >= CH_ZERO && text_char <= CH_NINE;
		is_e = (text_char & 8'hdf) == CH_UE;
		ws = text_char == CH_TAB || text_char == CH_SPACE || text_char == CH_LF
			|| text_char == CH_FF || text_char == CH_CR;
		sgn = text_char == CH_PLUS || text_char == CH_MINUS;
		d = dig ? 4'(text_char - CH_ZERO) : 4'd0;
		lt = letter(text_char);

		// extend a pending number
		if (s.phase != PH_IDLE) begin
			unique case (s.phase)
				PH_SIGN: begin
					if (dig) begin
						s = add_digit(s, d, 1'b0);
						s.phase = PH_INT;
						ext = 1'b1;
					end else if (text_char == CH_DOT) begin
						s.phase = PH_DOT;
						ext = 1'b1;
					end
				end
				PH_INT: begin
					if (dig) begin
						s = add_digit(s, d, 1'b0);
						ext = 1'b1;
					end else if (text_char == CH_DOT) begin
						s.phase = PH_FRAC;
						ext = 1'b1;
					end else if (is_e) begin
						s.phase = PH_EXP;
						ext = 1'b1;
					end
				end
				PH_DOT: begin
					if (dig) begin
						s = add_digit(s, d, 1'b1);
						s.phase = PH_FRAC;
						ext = 1'b1;
					end
				end
				PH_FRAC: begin
					if (dig) begin
						s = add_digit(s, d, 1'b1);
						ext = 1'b1;
					end else if (is_e) begin
						s.phase = PH_EXP;
						ext = 1'b1;
					end
				end
				PH_EXP: begin
					if (dig) begin
						s = add_exp(s, d);
						s.phase = PH_EXPDIG;
						ext = 1'b1;
					end else if (sgn) begin
						s.eneg = text_char == CH_MINUS;
						s.phase = PH_EXPSIGN;
						ext = 1'b1;
					end
				end
				PH_EXPSIGN, PH_EXPDIG: begin
					if (dig) begin
						s = add_exp(s, d);
						s.phase = PH_EXPDIG;
						ext = 1'b1;
					end
				end
				default: ext = 1'b0;
			endcase
			if (ext)
				taken = 1'b1;
			else
				finish(s, p, err);
		end

		// byte between tokens
		if (!taken && !err) begin
			if (ws) begin
				err = 1'b0;
			end else if (text_char == CH_COMMA) begin
				if (s.comma) begin
					s.comma = 1'b0;
				end else begin
					raise(s, p, ST_MALFORMED);
					err = 1'b1;
				end
			end else if (lt[5]) begin
				if (s.await_grp || s.pos != 3'd0) begin
					raise(s, p, ST_MALFORMED);
					err = 1'b1;
				end else if (!s.first && lt[3:0] != CMD_MOVE) begin
					raise(s, p, ST_NOT_MOVE);
					err = 1'b1;
				end else begin
					s.cmd = lt[3:0];
					s.abs_mode = lt[4];
					s.first = 1'b1;
					s.pos = 3'd0;
					s.comma = 1'b0;
					if (nargs(lt[3:0]) == 3'd0) begin
						s.await_grp = 1'b0;
						x = '0;
						x.cmd = lt[3:0];
						x.abs_mode = lt[4];
						x.done = 1'b1;
						x.status = ST_OK;
						p = put(p, x);
					end else begin
						s.await_grp = 1'b1;
					end
				end
			end else if (dig || sgn || text_char == CH_DOT) begin
				if (s.cmd >= 4'd10) begin
					raise(s, p, ST_NOT_MOVE);
					err = 1'b1;
				end else if (nargs(s.cmd) == 3'd0) begin
					raise(s, p, ST_MALFORMED);
					err = 1'b1;
				end else if (s.cmd == CMD_ARC && (s.pos == 3'd3 || s.pos == 3'd4)) begin
					// arc flags are single characters
					if (text_char == CH_ZERO || text_char == CH_ONE) begin
						p = put(p, arg_ent(s, 1'b0, text_char == CH_ONE));
						s = complete_st(s);
					end else begin
						raise(s, p, ST_MALFORMED);
						err = 1'b1;
					end
				end else if (s.cmd == CMD_ARC && s.pos < 3'd2 && sgn) begin
					raise(s, p, ST_MALFORMED);
					err = 1'b1;
				end else begin
					s = clear_num(s);
					s.comma = 1'b0;
					if (dig) begin
						s = add_digit(s, d, 1'b0);
						s.phase = PH_INT;
					end else if (text_char == CH_DOT) begin
						s.phase = PH_DOT;
					end else begin
						s.neg = text_char == CH_MINUS;
						s.phase = PH_SIGN;
					end
				end
			end else begin
				raise(s, p, ST_UNKNOWN);
				err = 1'b1;
			end
		end

		if (end_of_text) begin
			if (!err && s.phase != PH_IDLE)
				finish(s, p, err);
			if (!err && (s.await_grp || s.pos != 3'd0))
				raise(s, p, ST_MALFORMED);
			s = reset_st();
		end

		if (p.n == 2'd1)
			p.a.last = 1'b1;
		else if (p.n == 2'd2)
			p.b.last = 1'b1;

		st_d = s;
		push_d = p;
	end

	always_comb begin
		push = push_d;
		if (!take)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= reset_st();
		else if (take)
			st_q <= st_d;
	end

endmodule

/* hw/rtl/sptk_queue.sv */
module sptk_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  sptk_pkg::qpush_t push,
	input  logic             pop,
	output sptk_pkg::qent_t  head,
	output logic             head_valid,
	output logic             room
);
	import sptk_pkg::*;

	qent_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   count_q;

	assign head       = mem_q[rd_q];
	assign head_valid = count_q != '0;
	// a byte can leave up to two requests
	assign room       = count_q <= (QPTR_W+1)'(QDEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_q] <= push.a;
		if (push.n == 2'd2)
			mem_q[wr_q + QPTR_W'(1)] <= push.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(push.n);
			rd_q    <= rd_q + QPTR_W'(pop);
			count_q <= count_q + (QPTR_W+1)'(push.n) - (QPTR_W+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (count_q <= (QPTR_W+1)'(QDEPTH - 2)))
		else $error("queue overflow on double push");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH))
		else $error("queue count out of range");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3)
		else $error("more than two requests from one byte");

endmodule

/* hw/rtl/sptk_back.sv */
module sptk_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sptk_pkg::qent_t head,
	input  logic            head_valid,
	output logic            pop,
	output sptk_pkg::res_t  res,
	output logic            res_valid,
	input  logic            res_ready
);
	import sptk_pkg::*;

	bstate_t state_q, state_d;
	qent_t   ent_q;
	res_t    res_q, out_q;
	logic [WORK_W-1:0]       work_q;
	logic signed [EXP_W-1:0] cnt_q;
	logic [LIMB_IDX_W-1:0]   li_q;
	logic [3:0]              rem_q;
	logic                    over_q, nz_q, out_valid_q;

	logic [WORK_W+3:0]  mul_y;
	logic               mul_over;
	logic [LIMB_W-1:0]  limb, quo;
	logic [LIMB_W+3:0]  dividend;
	logic [39:0]        prod;
	logic [3:0]         rem_d;
	logic               pass_nz;
	logic               load_out;
	res_t               direct_res, fin_res;

	// times ten as shift and add
	assign mul_y    = (WORK_W+4)'({work_q, 3'b000}) + (WORK_W+4)'({work_q, 1'b0});
	assign mul_over = mul_y[WORK_W+3:WORK_W-32] != '0;

	// divide by ten one limb at a time, top limb first
	assign limb     = work_q[li_q*LIMB_W +: LIMB_W];
	assign dividend = {rem_q, limb};
	assign prod     = 40'(dividend) * 40'(RECIP10);
	assign quo      = prod[RECIP_SHIFT+LIMB_W-1:RECIP_SHIFT];
	assign rem_d    = 4'(dividend - (LIMB_W+4)'(quo) * (LIMB_W+4)'(10));
	assign pass_nz  = nz_q || quo != '0;

	always_comb begin
		direct_res = '0;
		direct_res.cmd      = head.cmd;
		direct_res.abs_mode = head.abs_mode;
		direct_res.idx      = head.idx;
		direct_res.value    = head.one ? 32'(64'd1 << FRAC_BITS) : 32'd0;
		direct_res.done     = head.done;
		direct_res.status   = head.status;
		direct_res.last     = head.last;
	end

	always_comb begin
		logic [63:0] qv, mag, limit, sval;
		logic sat;
		limit = ent_q.neg ? POS_MAX + 64'd1 : POS_MAX;
		qv = work_q[63:0];
		if (over_q || work_q[WORK_W-1:64] != '0) begin
			mag = limit;
			sat = 1'b1;
		end else begin
			mag = {1'b0, qv[63:1]} + {63'd0, qv[0]};
			sat = mag > limit;
			if (sat)
				mag = limit;
		end
		sval = ent_q.neg ? 64'd0 - mag : mag;
		fin_res = '0;
		fin_res.cmd      = ent_q.cmd;
		fin_res.abs_mode = ent_q.abs_mode;
		fin_res.idx      = ent_q.idx;
		fin_res.value    = sval[31:0];
		fin_res.done     = ent_q.done;
		fin_res.status   = sat ? ST_SATURATED : ent_q.status;
		fin_res.last     = ent_q.last;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					if (!head.conv || head.mant == '0)
						state_d = B_OUT;
					else if (head.expo > 0)
						state_d = B_MUL;
					else if (head.expo < 0)
						state_d = B_DIV;
					else
						state_d = B_FIN;
				end
			end
			B_MUL: begin
				if (mul_over || cnt_q == EXP_W'(1))
					state_d = B_FIN;
			end
			B_DIV: begin
				if (li_q == '0 && (!pass_nz || cnt_q == {EXP_W{1'b1}}))
					state_d = B_FIN;
			end
			B_FIN: state_d = B_OUT;
			B_OUT: begin
				if (!out_valid_q || res_ready)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = state_q == B_IDLE && head_valid;
		load_out = state_q == B_OUT && (!out_valid_q || res_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			li_q        <= '0;
			rem_q       <= '0;
			over_q      <= 1'b0;
			nz_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					cnt_q  <= head.expo;
					li_q   <= LIMB_IDX_W'(NLIMB - 1);
					rem_q  <= '0;
					over_q <= 1'b0;
					nz_q   <= 1'b0;
				end
				B_MUL: begin
					cnt_q <= cnt_q - EXP_W'(1);
					if (mul_over)
						over_q <= 1'b1;
				end
				B_DIV: begin
					if (li_q == '0) begin
						cnt_q <= cnt_q + EXP_W'(1);
						li_q  <= LIMB_IDX_W'(NLIMB - 1);
						rem_q <= '0;
						nz_q  <= 1'b0;
					end else begin
						li_q  <= li_q - LIMB_IDX_W'(1);
						rem_q <= rem_d;
						nz_q  <= pass_nz;
					end
				end
				default: over_q <= over_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				ent_q  <= head;
				work_q <= WORK_W'(head.mant) << (FRAC_BITS + 1);
				res_q  <= direct_res;
			end
			B_MUL: begin
				if (!mul_over)
					work_q <= mul_y[WORK_W-1:0];
			end
			B_DIV: work_q[li_q*LIMB_W +: LIMB_W] <= quo;
			B_FIN: res_q <= fin_res;
			default: res_q <= res_q;
		endcase
		if (load_out)
			out_q <= res_q;
	end

	assign res       = out_q;
	assign res_valid = out_valid_q;

	a_mul_needs_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_MUL || state_q == B_DIV) |-> ent_q.conv)
		else $error("scaling started for a request without a number");

	a_mul_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_MUL) |-> (cnt_q > 0))
		else $error("multiply pass with no exponent left");

	a_div_negative: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (cnt_q < 0))
		else $error("divide pass with no exponent left");

endmodule

/* hw/rtl/svg_path_data_tokenizer_core.sv */
// svg path data tokenizer: one text byte per request in, one result per request out:
// an argument, a close command or an error status
// scaling: a positive exponent step multiplies by ten, stopping early on overflow;
// a negative step divides by ten one 16-bit limb at a time, stopping early on zero
// throughput: one byte per cycle while the 4-entry queue has room for two requests
// reset: arst_n clears the parser state and the queue pointers at once; no clearing pass
module svg_path_data_tokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	// slave side: one text byte per request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_char
	input  logic        s_tlast,   // end_of_text
	// master side: one argument result per request
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [3:0] command, [4] is_absolute, [7:5] arg_index,
	                               // [39:8] arg_value, [40] group_done, [43:41] status,
	                               // [47:44] zero
	output logic        m_tlast    // last_of_run
);
	import sptk_pkg::*;

	qpush_t push;
	qent_t  head;
	res_t   res;
	logic   head_valid, pop, room, take;

	// the front classifies bytes and queues result requests;
	// the back converts numbers to fixed point
	assign s_tready = room;
	assign take     = s_tvalid && room;

	sptk_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_char   (s_tdata),
		.end_of_text (s_tlast),
		.take        (take),
		.push        (push)
	);

	// decouples parsing from the iterative scaling in the back
	sptk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.room       (room)
	);

	sptk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res        (res),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready)
	);

	// pack the result fields, lowest first
	assign m_tdata = {4'd0, res.status, res.done, res.value, res.idx, res.abs_mode, res.cmd};
	assign m_tlast = res.last;

endmodule
